### src/tfhgm_pkg.sv
// ----------------------------------------------------------------------------
// tfhgm_pkg
// Types, constants and text tables for the TCP frame HTTP GET matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package tfhgm_pkg;

    localparam int GET_LEN  = 4;
    localparam int PATH_LEN = 19;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in;

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        found_get;
        logic        found_path;
        logic        report;
        logic [15:0] payload_length;
        logic        short_frame;
    } t_out;

    typedef struct packed {
        logic [2:0] get_progress;
        logic [4:0] path_progress;
        logic       get_seen;
        logic       path_seen;
    } t_match;

    function automatic logic [7:0] f_get_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = "G";
            3'd1:    c = "E";
            3'd2:    c = "T";
            3'd3:    c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] f_path_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "/";
            5'd1:    c = "p";
            5'd2:    c = "r";
            5'd3:    c = "o";
            5'd4:    c = "c";
            5'd5:    c = "e";
            5'd6:    c = "s";
            5'd7:    c = "s";
            5'd8:    c = "o";
            5'd9:    c = ".";
            5'd10:   c = "p";
            5'd11:   c = "h";
            5'd12:   c = "p";
            5'd13:   c = "?";
            5'd14:   c = "p";
            5'd15:   c = "r";
            5'd16:   c = "o";
            5'd17:   c = "c";
            5'd18:   c = "=";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // header length in bytes from a 4-bit word count, at least 20
    function automatic logic [5:0] f_hdr_len(input logic [3:0] words);
        logic [5:0] b;
        b = {words, 2'b00};
        return (b < 6'd20) ? 6'd20 : b;
    endfunction

endpackage

`default_nettype wire

### src/tfhgm_scan.sv
// ----------------------------------------------------------------------------
// tfhgm_scan
// Payload text matchers: maps bytes outside 32..128 to '.' and advances both
// the GET and the request path matchers.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhgm_scan
    import tfhgm_pkg::*;
(
    input  wire logic [7:0] i_byte,
    input  wire logic       i_en,
    input  wire t_match     i_state,
    output t_match          o_state
);

    logic [7:0] c;
    logic [2:0] g;
    logic [4:0] q;

    always_comb begin
        c = (i_byte >= 8'd32 && i_byte <= 8'd128) ? i_byte : ".";
        o_state = i_state;
        g = i_state.get_progress;
        q = i_state.path_progress;

        if (i_en && !i_state.get_seen) begin
            if (g < 3'(GET_LEN) && f_get_char(g) == c) begin
                g = g + 3'd1;
            end else begin
                g = (c == f_get_char(3'd0)) ? 3'd1 : 3'd0;
            end
            if (g >= 3'(GET_LEN)) begin
                o_state.get_seen = 1'b1;
                g = 3'd0;
            end
            o_state.get_progress = g;
        end

        if (i_en && !i_state.path_seen) begin
            if (q < 5'(PATH_LEN) && f_path_char(q) == c) begin
                q = q + 5'd1;
            end else begin
                q = (c == f_path_char(5'd0)) ? 5'd1 : 5'd0;
            end
            if (q >= 5'(PATH_LEN)) begin
                o_state.path_seen = 1'b1;
                q = 5'd0;
            end
            o_state.path_progress = q;
        end
    end

endmodule

`default_nettype wire

### src/tcp_frame_http_get_matcher.sv
// ----------------------------------------------------------------------------
// tcp_frame_http_get_matcher
// Ethernet/IPv4/TCP frame parser with HTTP GET request path detection.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock while o_in_stall is low, with no gaps
// between frames. Each word lands in an input register and is parsed
// in one pass (header fields, payload start, both text matchers) into
// the frame state; the word marked frame_end yields one result word in
// the output register, or in a skid register behind it that holds a
// second result; input stalls only when two results wait downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_frame_http_get_matcher
    import tfhgm_pkg::*;
#(
    parameter int MAC_HEADER_BYTES = 14
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_in  i_in,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out      o_out,
    input  wire logic i_out_stall
);

    localparam logic [15:0] LP_M      = 16'(MAC_HEADER_BYTES);
    localparam logic [15:0] LP_POSMAX = 16'hFFFF;

    logic        r_in_valid;
    t_in         r_in;
    logic        r_out_valid;
    t_out        r_out;
    logic        r_skid_valid;
    t_out        r_skid;

    logic [15:0] r_pos;
    logic [5:0]  r_ihb,      n_ihb;
    logic [7:0]  r_pstart,   n_pstart;
    logic [31:0] r_src_addr, n_src_addr;
    logic [31:0] r_dst_addr, n_dst_addr;
    logic [15:0] r_src_port, n_src_port;
    logic [15:0] r_dst_port, n_dst_port;
    t_match      r_match,    n_match;

    logic [15:0] n_pos;
    logic [15:0] rel;
    logic [15:0] tcp_start;
    logic [15:0] tcp_off;
    logic        scan_en;
    logic        is_short;
    logic        in_acc;
    logic        fire;
    logic        res_new;
    logic        out_fire;
    t_out        res;

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_acc   = i_in_valid && !r_skid_valid;
    assign fire     = r_in_valid && !r_skid_valid;
    assign res_new  = fire && r_in.frame_end;
    assign out_fire = r_out_valid && !i_out_stall;

    always_comb begin
        n_ihb      = r_ihb;
        n_pstart   = r_pstart;
        n_src_addr = r_src_addr;
        n_dst_addr = r_dst_addr;
        n_src_port = r_src_port;
        n_dst_port = r_dst_port;
        rel        = r_pos - LP_M;
        tcp_off    = 16'd0;

        if (r_pos == LP_M) begin
            n_ihb    = f_hdr_len(r_in.data_byte[3:0]);
            n_pstart = 8'(LP_M) + {2'b00, n_ihb} + 8'd20;
        end

        if (r_pos >= LP_M) begin
            case (rel)
                16'd12:  n_src_addr[31:24] = r_in.data_byte;
                16'd13:  n_src_addr[23:16] = r_in.data_byte;
                16'd14:  n_src_addr[15:8]  = r_in.data_byte;
                16'd15:  n_src_addr[7:0]   = r_in.data_byte;
                16'd16:  n_dst_addr[31:24] = r_in.data_byte;
                16'd17:  n_dst_addr[23:16] = r_in.data_byte;
                16'd18:  n_dst_addr[15:8]  = r_in.data_byte;
                16'd19:  n_dst_addr[7:0]   = r_in.data_byte;
                default: ;
            endcase
        end

        tcp_start = LP_M + {10'd0, n_ihb};
        if (r_pos >= tcp_start) begin
            tcp_off = r_pos - tcp_start;
            case (tcp_off)
                16'd0:   n_src_port[15:8] = r_in.data_byte;
                16'd1:   n_src_port[7:0]  = r_in.data_byte;
                16'd2:   n_dst_port[15:8] = r_in.data_byte;
                16'd3:   n_dst_port[7:0]  = r_in.data_byte;
                16'd12:  n_pstart = 8'(tcp_start) + {2'b00, f_hdr_len(r_in.data_byte[7:4])};
                default: ;
            endcase
        end

        scan_en  = r_pos >= {8'd0, n_pstart};
        n_pos    = (r_pos == LP_POSMAX) ? r_pos : r_pos + 16'd1;
        is_short = n_pos < {8'd0, n_pstart};
    end

    tfhgm_scan u_scan (
        .i_byte  (r_in.data_byte),
        .i_en    (scan_en),
        .i_state (r_match),
        .o_state (n_match)
    );

    always_comb begin
        res.source_address = n_src_addr;
        res.dest_address   = n_dst_addr;
        res.source_port    = n_src_port;
        res.dest_port      = n_dst_port;
        res.found_get      = n_match.get_seen;
        res.found_path     = n_match.path_seen;
        res.report         = n_match.get_seen && n_match.path_seen;
        res.payload_length = is_short ? 16'd0 : n_pos - {8'd0, n_pstart};
        res.short_frame    = is_short;
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || res_new) begin
            r_pos      <= 16'd0;
            r_ihb      <= 6'd20;
            r_pstart   <= 8'(LP_M) + 8'd40;
            r_src_addr <= 32'd0;
            r_dst_addr <= 32'd0;
            r_src_port <= 16'd0;
            r_dst_port <= 16'd0;
            r_match    <= '0;
        end else if (fire) begin
            r_pos      <= n_pos;
            r_ihb      <= n_ihb;
            r_pstart   <= n_pstart;
            r_src_addr <= n_src_addr;
            r_dst_addr <= n_dst_addr;
            r_src_port <= n_src_port;
            r_dst_port <= n_dst_port;
            r_match    <= n_match;
        end
    end

    // handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_skid_valid) begin
                r_in_valid <= in_acc;
            end
            if (r_skid_valid) begin
                if (out_fire) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (res_new) begin
                if (!r_out_valid || out_fire) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload words
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
        end
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (res_new) begin
            if (!r_out_valid || out_fire) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

endmodule

`default_nettype wire

### src/tfhgm_checker.sv
// ----------------------------------------------------------------------------
// tfhgm_checker
// Port-level checks for the TCP frame HTTP GET matcher, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhgm_checker
    import tfhgm_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire t_out o_out,
    input wire logic i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("result word changed while stalled");

    a_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.report == (o_out.found_get && o_out.found_path)))
        else $error("report is not the conjunction of both matches");

    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.short_frame |->
            (o_out.payload_length == 16'd0) && !o_out.found_get && !o_out.found_path)
        else $error("short frame carries payload results");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("handshake not cleared by reset");

endmodule

bind tcp_frame_http_get_matcher tfhgm_checker u_tfhgm_checker (.*);

`default_nettype wire
